/* src/char_lcd_8bit_write_sequencer_assert.svh */
// ----------------------------------------------------------------------------
// Character LCD write sequencer - assertion macros
// Concurrent check wrappers; they compile to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_8BIT_WRITE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_8BIT_WRITE_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

`define CLSQ_ASSERT_HOLD(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("clsq: invariant violated");

`define CLSQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clsq: same-cycle implication violated");

`define CLSQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clsq: next-cycle implication violated");

`else

`define CLSQ_ASSERT_HOLD(label, cond)
`define CLSQ_ASSERT_IMP(label, ante, cons)
`define CLSQ_ASSERT_NXT(label, ante, cons)

`endif

`endif

/* src/clsq_pkg.sv */
// ----------------------------------------------------------------------------
// clsq_pkg
// Types, codes and init tables shared by the LCD write sequencer.
// ----------------------------------------------------------------------------
package clsq_pkg;

  // width of the microsecond wait counters (12..24)
  localparam int unsigned WAIT_CW  = 16;
  localparam int unsigned WAIT_MAX = (1 << WAIT_CW) - 1;

  localparam logic [3:0] INIT_STEPS = 4'd8;

  localparam logic [1:0] CFG_POWER_ON = 2'd0;
  localparam logic [1:0] CFG_CLEAR    = 2'd1;
  localparam logic [1:0] CFG_WRITE    = 2'd2;

  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_HOME      = 8'h02;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] LINE1_BASE    = 8'h00;
  localparam logic [7:0] LINE2_BASE    = 8'h40;

  localparam logic [7:0] INIT_BYTES [8] = '{
    8'h30, 8'h30, 8'h30, 8'h38, 8'h08, 8'h01, 8'h06, 8'h0C
  };

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_CMD    = 2'd1,
    KIND_CHAR   = 2'd2,
    KIND_CURSOR = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_POWER  = 3'd0,
    PH_ENABLE = 3'd1,
    PH_POST   = 3'd2,
    PH_EXTRA  = 3'd3,
    PH_IDLE   = 3'd4
  } phase_t;

  typedef struct packed {
    logic [15:0] power_on_wait_us;
    logic [15:0] clear_wait_us;
    logic [15:0] write_wait_us;
  } clsq_cfg_t;

  typedef struct packed {
    phase_t             phase;
    logic [WAIT_CW-1:0] wait_cnt;
    logic [3:0]         init_step;
    logic               rs;
    logic               en;
    logic [7:0]         data;
    logic [WAIT_CW-1:0] pend;
  } clsq_state_t;

  typedef struct packed {
    logic       rs;
    logic       en;
    logic [7:0] data;
    logic       busy_res;
    logic       init_done;
    logic       dropped;
  } clsq_res_t;

  function automatic logic [WAIT_CW-1:0] sat_wait(input logic [15:0] v);
    if (WAIT_CW >= 16) begin
      return WAIT_CW'(v);
    end else if (32'(v) > WAIT_MAX) begin
      return WAIT_CW'(WAIT_MAX);
    end else begin
      return WAIT_CW'(v);
    end
  endfunction

  function automatic logic [WAIT_CW-1:0] cmd_extra(input logic [7:0]  cmd,
                                                   input clsq_cfg_t  cfg);
    if (cmd == CMD_CLEAR || cmd == CMD_HOME) begin
      return sat_wait(cfg.clear_wait_us);
    end else begin
      return sat_wait(cfg.write_wait_us);
    end
  endfunction

  // gap after each init write: fixed for the three 0x30 strobes
  function automatic logic [WAIT_CW-1:0] init_extra(input logic [3:0] step,
                                                    input clsq_cfg_t  cfg);
    logic [15:0] gap;
    gap = 16'd0;
    case (step)
      4'd0:    gap = 16'd10000;
      4'd1:    gap = 16'd200;
      4'd2:    gap = 16'd200;
      default: gap = 16'd0;
    endcase
    if (step < 4'd3) begin
      return sat_wait(gap);
    end else begin
      return cmd_extra(INIT_BYTES[step[2:0]], cfg);
    end
  endfunction

endpackage

/* src/clsq_step.sv */
// ----------------------------------------------------------------------------
// clsq_step
// Next-state and result logic for one microsecond tick of the sequencer.
// ----------------------------------------------------------------------------
module clsq_step (
  input  clsq_pkg::clsq_state_t cur,
  input  clsq_pkg::clsq_cfg_t   cfg,
  input  logic [1:0]            kind,
  input  logic [7:0]            value,
  input  logic [7:0]            col,
  input  logic [7:0]            row,
  output clsq_pkg::clsq_state_t nxt,
  output clsq_pkg::clsq_res_t   res
);
  import clsq_pkg::*;

  always_comb begin
    logic               go_extra;
    logic               go_finish;
    logic               dropped;
    logic [7:0]         base;
    logic [7:0]         col_eff;
    logic [7:0]         addr;
    logic [WAIT_CW-1:0] post_n;
    phase_t             ph;

    go_extra  = 1'b0;
    go_finish = 1'b0;
    dropped   = 1'b0;
    base      = (row == 8'd1) ? LINE1_BASE : LINE2_BASE;
    col_eff   = (col == 8'd0) ? 8'd1 : col;
    addr      = base + col_eff - 8'd1;
    post_n    = sat_wait(cfg.write_wait_us);
    nxt       = cur;

    // power-on wait over: first init strobe goes out this tick
    if (nxt.phase == PH_POWER && nxt.wait_cnt >= sat_wait(cfg.power_on_wait_us)) begin
      nxt.rs    = 1'b0;
      nxt.data  = INIT_BYTES[nxt.init_step[2:0]];
      nxt.en    = 1'b1;
      nxt.pend  = init_extra(nxt.init_step, cfg);
      nxt.phase = PH_ENABLE;
    end

    if (kind_t'(kind) != KIND_TICK) begin
      if (nxt.phase == PH_IDLE) begin
        nxt.en    = 1'b1;
        nxt.phase = PH_ENABLE;
        case (kind_t'(kind))
          KIND_CMD: begin
            nxt.rs   = 1'b0;
            nxt.data = value;
            nxt.pend = cmd_extra(value, cfg);
          end
          KIND_CHAR: begin
            nxt.rs   = 1'b1;
            nxt.data = value;
            nxt.pend = sat_wait(cfg.write_wait_us);
          end
          default: begin
            nxt.rs   = 1'b0;
            nxt.data = CMD_SET_DDRAM | addr;
            nxt.pend = sat_wait(cfg.write_wait_us);
          end
        endcase
      end else begin
        dropped = 1'b1;
      end
    end

    res.rs        = nxt.rs;
    res.en        = nxt.en;
    res.data      = nxt.data;
    res.busy_res  = (nxt.phase != PH_IDLE);
    res.init_done = (nxt.init_step >= INIT_STEPS);
    res.dropped   = dropped;

    ph = nxt.phase;
    unique case (ph)
      PH_POWER: begin
        if (nxt.wait_cnt != '1) begin
          nxt.wait_cnt = nxt.wait_cnt + WAIT_CW'(1);
        end
      end
      PH_ENABLE: begin
        nxt.en = 1'b0;
        if (post_n == '0) begin
          go_extra = 1'b1;
        end else begin
          nxt.phase    = PH_POST;
          nxt.wait_cnt = post_n;
        end
      end
      PH_POST: begin
        if (nxt.wait_cnt != '0) begin
          nxt.wait_cnt = nxt.wait_cnt - WAIT_CW'(1);
        end
        go_extra = (nxt.wait_cnt == '0);
      end
      PH_EXTRA: begin
        if (nxt.wait_cnt != '0) begin
          nxt.wait_cnt = nxt.wait_cnt - WAIT_CW'(1);
        end
        go_finish = (nxt.wait_cnt == '0);
      end
      default: begin
      end
    endcase

    // zero extra wait falls straight through to the end of the write
    if (go_extra) begin
      if (nxt.pend == '0) begin
        go_finish = 1'b1;
      end else begin
        nxt.phase    = PH_EXTRA;
        nxt.wait_cnt = nxt.pend;
      end
    end

    if (go_finish) begin
      nxt.en    = 1'b0;
      nxt.phase = PH_IDLE;
      if (nxt.init_step < INIT_STEPS) begin
        nxt.init_step = nxt.init_step + 4'd1;
        if (nxt.init_step < INIT_STEPS) begin
          nxt.rs    = 1'b0;
          nxt.data  = INIT_BYTES[nxt.init_step[2:0]];
          nxt.en    = 1'b1;
          nxt.pend  = init_extra(nxt.init_step, cfg);
          nxt.phase = PH_ENABLE;
        end
      end
    end
  end

endmodule

/* src/char_lcd_8bit_write_sequencer.sv */
// An accepted tick's result is in the output register in the next cycle.
// Throughput: one tick per cycle while in_stall is low; the tick's whole update is one pass of clsq_step.
// in_stall is high only while a held result is stalled downstream.
// Reset (rst_n low, synchronous) restores default wait registers and restarts
// the power-on wait; no result is valid until a tick is accepted.
// ----------------------------------------------------------------------------
// Character LCD 8-bit write sequencer
// Power-on init and byte/cursor writes timed in microsecond ticks.
// ----------------------------------------------------------------------------
`include "char_lcd_8bit_write_sequencer_assert.svh"

module char_lcd_8bit_write_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_value,
  input  logic [7:0]  in_col,
  input  logic [7:0]  in_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_rs,
  output logic        out_en,
  output logic [7:0]  out_data,
  output logic        out_busy_res,
  output logic        out_init_done,
  output logic        out_dropped,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import clsq_pkg::*;

  clsq_cfg_t   cfg_r;
  clsq_state_t state_r;
  clsq_state_t state_nxt;
  clsq_res_t   res_nxt;
  clsq_res_t   res_r;
  logic        out_valid_r;
  logic        in_accept;

  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.power_on_wait_us <= 16'd50000;
      cfg_r.clear_wait_us    <= 16'd2000;
      cfg_r.write_wait_us    <= 16'd50;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POWER_ON: cfg_r.power_on_wait_us <= cfg_wdata;
        CFG_CLEAR:    cfg_r.clear_wait_us    <= cfg_wdata;
        CFG_WRITE:    cfg_r.write_wait_us    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  clsq_step u_step (
    .cur   (state_r),
    .cfg   (cfg_r),
    .kind  (in_kind),
    .value (in_value),
    .col   (in_col),
    .row   (in_row),
    .nxt   (state_nxt),
    .res   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase     <= PH_POWER;
      state_r.wait_cnt  <= '0;
      state_r.init_step <= '0;
      state_r.rs        <= 1'b0;
      state_r.en        <= 1'b0;
      state_r.data      <= '0;
      state_r.pend      <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      if (in_accept) begin
        state_r <= state_nxt;
      end
      out_valid_r <= in_accept | (out_valid_r & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_rs        = res_r.rs;
  assign out_en        = res_r.en;
  assign out_data      = res_r.data;
  assign out_busy_res  = res_r.busy_res;
  assign out_init_done = res_r.init_done;
  assign out_dropped   = res_r.dropped;

  `CLSQ_ASSERT_NXT(a_accept_loads_result, in_accept, out_valid_r)
  `CLSQ_ASSERT_HOLD(a_init_step_range, state_r.init_step <= INIT_STEPS)
  `CLSQ_ASSERT_IMP(a_idle_after_init, state_r.phase == PH_IDLE, state_r.init_step == INIT_STEPS)
  `CLSQ_ASSERT_IMP(a_idle_enable_low, state_r.phase == PH_IDLE, !state_r.en)
  `CLSQ_ASSERT_IMP(a_drop_only_busy, out_valid_r && res_r.dropped, res_r.busy_res)

endmodule
